### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that cond never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

### rtl/fba_pkg.sv
package fba_pkg;

   // Largest pool the bump counter may hand out before indexes run out.
   localparam int MAX_BLOCKS = 256;

   localparam int IDX_W    = 8;
   localparam int DEPTH    = 1 << IDX_W;
   localparam int CNT_W    = 9;
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 32;
   localparam int TOTAL_W  = 32;
   localparam int STATUS_W = 2;
   localparam int PROD_W   = IDX_W + SIZE_W;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [CNT_W-1:0] USED_MAX = {CNT_W{1'b1}};

   // Operation codes.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERSIZE  = 2'd2;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_BLOCK_LIMIT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_POOL_BASE   = 2'd2;

   localparam logic [CNT_W-1:0]  LIMIT_RESET = 9'd256;
   localparam logic [SIZE_W-1:0] BYTES_RESET = 16'd64;
   localparam logic [ADDR_W-1:0] BASE_RESET  = 32'd0;

   typedef struct packed {
      logic accept;
      logic exec;
   } fba_cmd_type;

   typedef struct packed {
      logic pop_pending;
   } fba_sts_type;

   typedef struct packed {
      logic [CNT_W-1:0]  block_limit;
      logic [SIZE_W-1:0] block_bytes;
      logic [ADDR_W-1:0] pool_base;
   } fba_cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]    granted_index;
      logic [ADDR_W-1:0]   granted_address;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    in_use;
      logic [CNT_W-1:0]    peak_in_use;
      logic [TOTAL_W-1:0]  alloc_total;
      logic [TOTAL_W-1:0]  free_total;
   } fba_rsp_type;

endpackage

### rtl/fba_channels.sv
interface fba_req_if
   import fba_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [SIZE_W-1:0] request_size;
   logic [IDX_W-1:0]  block_index;

   modport source (output valid, func, request_size, block_index, input ready);
   modport sink   (input valid, func, request_size, block_index, output ready);
endinterface

interface fba_rsp_if
   import fba_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    granted_index;
   logic [ADDR_W-1:0]   granted_address;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    in_use;
   logic [CNT_W-1:0]    peak_in_use;
   logic [TOTAL_W-1:0]  alloc_total;
   logic [TOTAL_W-1:0]  free_total;

   modport source (output valid, granted_index, granted_address, status, in_use,
                   peak_in_use, alloc_total, free_total, input ready);
   modport sink   (input valid, granted_index, granted_address, status, in_use,
                   peak_in_use, alloc_total, free_total, output ready);
endinterface

### rtl/fba_ram.sv
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fba_regs.sv
module fba_regs
   import fba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output fba_cfg_type       cfg
);

   fba_cfg_type           cfg_ff, cfg_in;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  reg_idx;

   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BLOCK_LIMIT: cfg_in.block_limit = csr_pwdata[CNT_W-1:0];
            REG_BLOCK_BYTES: cfg_in.block_bytes = csr_pwdata[SIZE_W-1:0];
            REG_POOL_BASE:   cfg_in.pool_base   = csr_pwdata[ADDR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BLOCK_LIMIT: csr_prdata = {{(CSR_DW-CNT_W){1'b0}}, cfg_ff.block_limit};
         REG_BLOCK_BYTES: csr_prdata = {{(CSR_DW-SIZE_W){1'b0}}, cfg_ff.block_bytes};
         REG_POOL_BASE:   csr_prdata = cfg_ff.pool_base;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_limit <= LIMIT_RESET;
         cfg_ff.block_bytes <= BYTES_RESET;
         cfg_ff.pool_base   <= BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/fba_dp.sv
module fba_dp
   import fba_pkg::*;
#(
   parameter int POOL_BLOCKS = MAX_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  fba_cmd_type       cmd,
   input  logic              func,
   input  logic [SIZE_W-1:0] request_size,
   input  logic [IDX_W-1:0]  block_index,
   input  fba_cfg_type       cfg,
   output fba_sts_type       sts,
   output fba_rsp_type       rsp
);

   // Bump bound never exceeds the pool or the index space.
   localparam int CAP_INT = (POOL_BLOCKS < DEPTH) ? POOL_BLOCKS : DEPTH;
   localparam logic [CNT_W-1:0] BUMP_CAP = CNT_W'(CAP_INT);

   // Free-list state.
   logic [IDX_W-1:0]   head_ff, head_in;
   logic               nonempty_ff, nonempty_in;
   logic [CNT_W-1:0]   bump_ff, bump_in;
   logic [TOTAL_W-1:0] alloc_ff, alloc_in;
   logic [TOTAL_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   peak_ff, peak_in;
   logic               pop_ff, pop_in;

   // Per-item values carried into the execute cycle.
   logic [IDX_W-1:0]    idx_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                got_ff;
   logic [STATUS_W-1:0] status_ff;

   fba_rsp_type rsp_ff;

   logic                is_alloc, oversize, bump_ok, take_list, take_bump, got;
   logic [CNT_W-1:0]    bound;
   logic [IDX_W-1:0]    sel_idx;
   logic [PROD_W-1:0]   prod_in;
   logic [STATUS_W-1:0] status_in;
   logic [IDX_W:0]      link_rd;

   assign is_alloc  = (func == FUNC_ALLOC);
   assign oversize  = request_size > cfg.block_bytes;
   assign bound     = (cfg.block_limit < BUMP_CAP) ? cfg.block_limit : BUMP_CAP;
   assign bump_ok   = bump_ff < bound;
   assign take_list = is_alloc & ~oversize & nonempty_ff;
   assign take_bump = is_alloc & ~oversize & ~nonempty_ff & bump_ok;
   assign got       = take_list | take_bump;
   assign sel_idx   = take_list ? head_ff : bump_ff[IDX_W-1:0];
   assign prod_in   = {{SIZE_W{1'b0}}, sel_idx} * {{IDX_W{1'b0}}, cfg.block_bytes};

   always_comb begin
      if (!is_alloc || got) begin
         status_in = STATUS_OK;
      end else if (oversize) begin
         status_in = STATUS_OVERSIZE;
      end else begin
         status_in = STATUS_EXHAUSTED;
      end
   end

   // Link entry: {list continues past this entry, next index}.
   fba_ram #(
      .WIDTH (IDX_W + 1),
      .DEPTH (DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.accept & ~is_alloc),
      .wr_addr (block_index),
      .wr_data ({nonempty_ff, head_ff}),
      .rd_en   (cmd.accept & take_list),
      .rd_addr (head_ff),
      .rd_data (link_rd)
   );

   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      bump_in     = bump_ff;
      alloc_in    = alloc_ff;
      free_in     = free_ff;
      used_in     = used_ff;
      peak_in     = peak_ff;
      pop_in      = pop_ff;
      if (cmd.accept) begin
         pop_in = take_list;
         if (is_alloc) begin
            if (take_bump) begin
               bump_in = bump_ff + 1'b1;
            end
            if (got) begin
               alloc_in = alloc_ff + 1'b1;
               if (used_ff != USED_MAX) begin
                  used_in = used_ff + 1'b1;
               end
               if (used_in > peak_ff) begin
                  peak_in = used_in;
               end
            end
         end else begin
            head_in     = block_index;
            nonempty_in = 1'b1;
            free_in     = free_ff + 1'b1;
            if (used_ff != '0) begin
               used_in = used_ff - 1'b1;
            end
         end
      end else if (cmd.exec && pop_ff) begin
         // Follow the link read at the accept edge.
         head_in     = link_rd[IDX_W-1:0];
         nonempty_in = link_rd[IDX_W];
         pop_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         bump_ff     <= '0;
         alloc_ff    <= '0;
         free_ff     <= '0;
         used_ff     <= '0;
         peak_ff     <= '0;
         pop_ff      <= 1'b0;
      end else begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         bump_ff     <= bump_in;
         alloc_ff    <= alloc_in;
         free_ff     <= free_in;
         used_ff     <= used_in;
         peak_ff     <= peak_in;
         pop_ff      <= pop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff    <= got ? sel_idx : '0;
         prod_ff   <= prod_in;
         got_ff    <= got;
         status_ff <= status_in;
      end
      if (cmd.exec) begin
         rsp_ff.granted_index   <= idx_ff;
         rsp_ff.granted_address <= got_ff ?
            (cfg.pool_base + {{(ADDR_W-PROD_W){1'b0}}, prod_ff}) : '0;
         rsp_ff.status          <= status_ff;
         rsp_ff.in_use          <= used_ff;
         rsp_ff.peak_in_use     <= peak_ff;
         rsp_ff.alloc_total     <= alloc_ff;
         rsp_ff.free_total      <= free_ff;
      end
   end

   assign sts.pop_pending = pop_ff;
   assign rsp             = rsp_ff;

endmodule

### rtl/fba_ctrl.sv
`include "assert_macros.svh"

module fba_ctrl
   import fba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  fba_sts_type sts,
   output fba_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Take a new transaction only when the result register is free or draining now.
   assign req_ready  = (state_ff == ST_IDLE) & (~rsp_valid_ff | rsp_ready);
   assign cmd.accept = req_valid & req_ready;
   assign cmd.exec   = (state_ff == ST_EXEC);

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = cmd.accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_ALWAYS(a_accept_then_exec, clock, reset, cmd.accept |=> cmd.exec)
   `ASSERT_ALWAYS(a_exec_gives_result, clock, reset, cmd.exec |=> rsp_valid_ff)
   `ASSERT_ALWAYS(a_exec_single_cycle, clock, reset, cmd.exec |=> !cmd.exec)
   `ASSERT_NEVER(a_pop_outside_exec, clock, reset, sts.pop_pending && !cmd.exec)

endmodule

### rtl/fixed_block_allocator.sv
// Fixed-size block pool allocator with a LIFO free list.
//
// req_ch carries one transaction per operation: func selects allocate or free,
// request_size is checked against block_bytes on allocate, block_index names
// the block returned on free. rsp_ch returns exactly one transaction per
// request: granted index and byte address (pool_base + index * block_bytes),
// a status code and the usage counters after the operation.
// The csr_ port is APB-style: block_limit at 0x0, block_bytes at 0x4 and
// pool_base at 0x8; write it only while no request is in flight.
//
// An accepted request moves to the execute state, where the result register is
// loaded; the result is then presented until taken. No new request is taken
// while one is executing. The free-list link memory has a registered read, so a
// pop updates the list head from that read in the execute state.
// A stalled rsp_ch holds the result in its output register and blocks the
// next request until that result is taken.
// Reset clears the list head, the bump counter and all counters and loads the
// register defaults; the link memory needs no clearing pass because a pop only
// ever reads entries written by an earlier free.
module fixed_block_allocator
   import fba_pkg::*;
#(
   parameter int POOL_BLOCKS = MAX_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   fba_req_if.sink           req_ch,
   fba_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   fba_cfg_type cfg;
   fba_cmd_type cmd;
   fba_sts_type sts;
   fba_rsp_type rsp;

   // Configuration registers.
   fba_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake sequencing: accept, execute, hold the result until taken.
   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Free list, bump counter, usage counters and the result register.
   fba_dp #(
      .POOL_BLOCKS (POOL_BLOCKS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .func         (req_ch.func),
      .request_size (req_ch.request_size),
      .block_index  (req_ch.block_index),
      .cfg          (cfg),
      .sts          (sts),
      .rsp          (rsp)
   );

   // Drive the result channel payload from the result register.
   assign rsp_ch.granted_index   = rsp.granted_index;
   assign rsp_ch.granted_address = rsp.granted_address;
   assign rsp_ch.status          = rsp.status;
   assign rsp_ch.in_use          = rsp.in_use;
   assign rsp_ch.peak_in_use     = rsp.peak_in_use;
   assign rsp_ch.alloc_total     = rsp.alloc_total;
   assign rsp_ch.free_total      = rsp.free_total;

endmodule
